@@ sv/sprm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell pair row index remap package
// Shared sizes, request codes, payload types and the controller interface.
// ----------------------------------------------------------------------------
package sprm_pkg;

  localparam int MAX_PAIRS = 32;
  localparam int MAX_ROWS  = 32;
  localparam int MAX_AM    = 7;

  localparam int AM_W    = 3;
  localparam int VAL_W   = 16;
  localparam int CART_W  = 6;
  localparam int SIZE_W  = 11;
  localparam int PAIR_IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PAIR_CW = $clog2(MAX_PAIRS + 1);
  localparam int ROW_IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CW  = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] REQ_LOAD_PAIR = 2'd0;
  localparam logic [1:0] REQ_LOAD_ROW  = 2'd1;
  localparam logic [1:0] REQ_RUN       = 2'd2;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  localparam logic [VAL_W-1:0] VAL_SAT = {VAL_W{1'b1}};

  typedef struct packed {
    logic [1:0]      req_type;
    logic [AM_W-1:0] am_first;
    logic [AM_W-1:0] am_second;
    logic [VAL_W-1:0] row_index;
  } in_req_t;

  typedef struct packed {
    logic             result_kind;
    logic [VAL_W-1:0] result_value;
    logic             row_not_found;
    logic             last_result;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPACT,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic load_pair;
    logic load_row;
    logic clear_counts;
    logic run_init;
    logic srch_step;
    logic cmp_step;
    logic row_step;
  } dp_cmd_t;

  typedef struct packed {
    logic row_cnt_zero;
    logic row_done;
    logic last_row;
    logic last_pair;
  } dp_status_t;

  function automatic logic [CART_W-1:0] cart_count(input logic [AM_W-1:0] am);
    logic [AM_W-1:0]  l;
    logic [CART_W:0]  p;
    l = (am > AM_W'(MAX_AM)) ? AM_W'(MAX_AM) : am;
    p = ((CART_W+1)'(l) + (CART_W+1)'(1)) * ((CART_W+1)'(l) + (CART_W+1)'(2));
    return CART_W'(p >> 1);
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    return s[VAL_W] ? VAL_SAT : s[VAL_W-1:0];
  endfunction

endpackage

@@ sv/sprm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell pair row index remap controller
// Decodes requests and sequences the search, compaction and row phases.
// ----------------------------------------------------------------------------
module sprm_ctrl
  import sprm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && req_type == REQ_RUN && !st.row_cnt_zero) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (st.row_done && st.last_row) begin
          state_nxt = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (st.last_pair) begin
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (st.last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (req_type)
            REQ_LOAD_PAIR: cmd.load_pair = 1'b1;
            REQ_LOAD_ROW:  cmd.load_row  = 1'b1;
            REQ_RUN: begin
              if (st.row_cnt_zero) begin
                cmd.clear_counts = 1'b1;
              end else begin
                cmd.run_init = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_SEARCH:  cmd.srch_step = 1'b1;
      ST_COMPACT: cmd.cmp_step  = 1'b1;
      ST_ROWS:    cmd.row_step  = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ sv/sprm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell pair row index remap datapath
// Pair and row stores, the offset walk, compaction and the result register.
// ----------------------------------------------------------------------------
module sprm_dp
  import sprm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  in_req_t    in_data,
  output dp_status_t st,
  output logic       out_valid,
  output out_res_t   out_data
);

  logic [SIZE_W-1:0]  pair_size_r  [MAX_PAIRS];
  logic [VAL_W-1:0]   comp_base_r  [MAX_PAIRS];
  logic [MAX_PAIRS-1:0] used_r, used_nxt;
  logic [VAL_W-1:0]   target_row_r [MAX_ROWS];
  logic [PAIR_IW-1:0] tgt_pair_r   [MAX_ROWS];
  logic [SIZE_W-1:0]  tgt_within_r [MAX_ROWS];
  logic [MAX_ROWS-1:0] tgt_found_r;

  logic [PAIR_CW-1:0] pair_cnt_r, pair_cnt_nxt;
  logic [ROW_CW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [ROW_IW-1:0]  i_r, i_nxt;
  logic [PAIR_IW-1:0] j_r, j_nxt;
  logic [VAL_W-1:0]   start_r, start_nxt;
  logic [VAL_W-1:0]   comp_r, comp_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_data_r, out_data_nxt;

  logic [SIZE_W-1:0]   size_j;
  logic [VAL_W-1:0]    end_j;
  logic [VAL_W-1:0]    x_i;
  logic                hit;
  logic [PAIR_CW:0]    j_inc;
  logic [ROW_CW:0]     i_inc;
  logic                j_last;
  logic                i_last;
  logic [2*CART_W-1:0] size_prod;
  logic [PAIR_IW-1:0]  p_i;
  logic [VAL_W-1:0]    row_val;
  logic                wr_pair;
  logic                wr_row;
  logic                wr_tgt;
  logic                wr_base;

  assign size_j = pair_size_r[j_r];
  assign end_j  = sat_add(start_r, VAL_W'(size_j));
  assign x_i    = target_row_r[i_r];
  assign hit    = (pair_cnt_r != '0) && (x_i < end_j);
  assign j_inc  = (PAIR_CW+1)'(j_r) + (PAIR_CW+1)'(1);
  assign i_inc  = (ROW_CW+1)'(i_r) + (ROW_CW+1)'(1);
  assign j_last = j_inc >= {1'b0, pair_cnt_r};
  assign i_last = i_inc >= {1'b0, row_cnt_r};

  assign size_prod = (2*CART_W)'(cart_count(in_data.am_first))
                   * (2*CART_W)'(cart_count(in_data.am_second));

  assign p_i     = tgt_pair_r[i_r];
  assign row_val = sat_add(VAL_W'(tgt_within_r[i_r]), comp_base_r[p_i]);

  assign wr_pair = cmd.load_pair && (pair_cnt_r < PAIR_CW'(MAX_PAIRS));
  assign wr_row  = cmd.load_row && (row_cnt_r < ROW_CW'(MAX_ROWS));
  assign wr_tgt  = cmd.srch_step && (hit || j_last);
  assign wr_base = cmd.cmp_step && used_r[j_r];

  assign st.row_cnt_zero = (row_cnt_r == '0);
  assign st.row_done     = hit || j_last;
  assign st.last_row     = i_last;
  assign st.last_pair    = j_last;

  always_comb begin
    pair_cnt_nxt  = pair_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    start_nxt     = start_r;
    comp_nxt      = comp_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    if (wr_pair) begin
      pair_cnt_nxt = pair_cnt_r + PAIR_CW'(1);
    end
    if (wr_row) begin
      row_cnt_nxt = row_cnt_r + ROW_CW'(1);
    end
    if (cmd.clear_counts) begin
      pair_cnt_nxt = '0;
      row_cnt_nxt  = '0;
    end
    if (cmd.run_init) begin
      i_nxt     = '0;
      j_nxt     = '0;
      start_nxt = '0;
      comp_nxt  = '0;
      used_nxt  = '0;
    end
    if (cmd.srch_step) begin
      if (hit || j_last) begin
        if (hit) begin
          used_nxt[j_r] = 1'b1;
        end
        i_nxt     = i_last ? '0 : i_r + ROW_IW'(1);
        j_nxt     = '0;
        start_nxt = '0;
      end else begin
        j_nxt     = j_r + PAIR_IW'(1);
        start_nxt = end_j;
      end
    end
    if (cmd.cmp_step) begin
      j_nxt = j_last ? '0 : j_r + PAIR_IW'(1);
      if (used_r[j_r]) begin
        comp_nxt                   = sat_add(comp_r, VAL_W'(size_j));
        out_valid_nxt              = 1'b1;
        out_data_nxt.result_kind   = KIND_PAIR;
        out_data_nxt.result_value  = VAL_W'(j_r);
        out_data_nxt.row_not_found = 1'b0;
        out_data_nxt.last_result   = 1'b0;
      end
    end
    if (cmd.row_step) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.result_kind   = KIND_ROW;
      out_data_nxt.result_value  = tgt_found_r[i_r] ? row_val : '0;
      out_data_nxt.row_not_found = !tgt_found_r[i_r];
      out_data_nxt.last_result   = i_last;
      i_nxt = i_last ? '0 : i_r + ROW_IW'(1);
      if (i_last) begin
        pair_cnt_nxt = '0;
        row_cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r  <= '0;
      row_cnt_r   <= '0;
      i_r         <= '0;
      j_r         <= '0;
      start_r     <= '0;
      comp_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pair_cnt_r  <= pair_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      start_r     <= start_nxt;
      comp_r      <= comp_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (wr_pair) begin
      pair_size_r[pair_cnt_r[PAIR_IW-1:0]] <= SIZE_W'(size_prod);
    end
    if (wr_row) begin
      target_row_r[row_cnt_r[ROW_IW-1:0]] <= in_data.row_index;
    end
    if (wr_tgt) begin
      tgt_pair_r[i_r]   <= j_r;
      tgt_within_r[i_r] <= SIZE_W'(x_i - start_r);
      tgt_found_r[i_r]  <= hit;
    end
    if (wr_base) begin
      comp_base_r[j_r] <= comp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/shell_pair_row_index_remap_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell pair row index remap core
// Loads shell pairs and target rows, then emits used pair positions and the
// remapped row indices within the compacted pair layout.
// ----------------------------------------------------------------------------
// A load request leaves busy low, so loads may be issued back to back. A run
// request raises busy for the whole run: the search walks the pair list from
// the start for each row, one pair per cycle until the row's pair is found,
// then the compaction steps through each loaded pair in turn (at least one
// step), then the row phase steps through each row in turn. Results are
// registered and appear in the cycle after the step that makes them, each for
// one cycle with out_valid high, and the receiver cannot stall them; the last
// one carries last_result and coincides with busy falling. A run with no rows
// loaded gives no result and leaves busy low. Every run empties both lists.
// ----------------------------------------------------------------------------
module shell_pair_row_index_remap_core
  import sprm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_res_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  sprm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  sprm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe outside a run");

  a_last_is_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_result) |-> (out_data.result_kind == KIND_ROW && !busy))
    else $error("last result is not a row or the run goes on");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_not_found)
      |-> (out_data.result_value == '0 && out_data.result_kind == KIND_ROW))
    else $error("row not found result carries a value");
`endif

endmodule

@@ bench/shell_pair_row_index_remap_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell pair row index remap core testbench
// Loads shell pair and target row lists, issues run requests and checks every
// emitted pair position and remapped row index against a behavioural
// prediction of the block, through directed cases followed by random batches.
// ----------------------------------------------------------------------------
module shell_pair_row_index_remap_core_test;
  import sprm_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_valid;
  out_res_t out_data;

  int         pair_sz [MAX_PAIRS];
  logic [15:0] row_tgt [MAX_ROWS];
  int         n_pairs = 0;
  int         n_rows = 0;
  out_res_t   remap_q[$];
  out_res_t   want_res;
  int         mismatches = 0;
  int         cycles = 0;
  bit         gaps_on = 1'b1;

  shell_pair_row_index_remap_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int orbital_count(input int am);
    int l;
    l = (am > MAX_AM) ? MAX_AM : am;
    return (l + 1) * (l + 2) / 2;
  endfunction

  function automatic int clip16(input int v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic in_req_t mk(input logic [1:0] req, input int a, input int b,
                                 input logic [15:0] row);
    in_req_t r;
    r.req_type  = req;
    r.am_first  = AM_W'(a);
    r.am_second = AM_W'(b);
    r.row_index = row;
    return r;
  endfunction

  // Applies one accepted request to the shadow lists and queues the results of a run.
  function automatic void predict_remap(input in_req_t r);
    int off [MAX_PAIRS+1];
    int comp [MAX_PAIRS+1];
    int rank [MAX_PAIRS];
    int hit [MAX_ROWS];
    bit used [MAX_PAIRS];
    bit fnd [MAX_ROWS];
    int n_used;
    int x;
    out_res_t run_res[$];
    out_res_t e;
    case (r.req_type)
      REQ_LOAD_PAIR: begin
        if (n_pairs < MAX_PAIRS) begin
          pair_sz[n_pairs] = orbital_count(r.am_first) * orbital_count(r.am_second);
          n_pairs++;
        end
      end
      REQ_LOAD_ROW: begin
        if (n_rows < MAX_ROWS) begin
          row_tgt[n_rows] = r.row_index;
          n_rows++;
        end
      end
      REQ_RUN: begin
        off[0] = 0;
        for (int i = 0; i < n_pairs; i++) begin
          off[i+1] = clip16(off[i] + pair_sz[i]);
          used[i] = 1'b0;
        end
        for (int i = 0; i < n_rows; i++) begin
          x = row_tgt[i];
          fnd[i] = 1'b0;
          hit[i] = 0;
          for (int j = 0; j < n_pairs; j++) begin
            if (off[j] <= x && x < off[j+1]) begin
              fnd[i] = 1'b1;
              hit[i] = j;
              used[j] = 1'b1;
              break;
            end
          end
        end
        n_used = 0;
        comp[0] = 0;
        for (int i = 0; i < n_pairs; i++) begin
          if (used[i]) begin
            rank[i] = n_used;
            comp[n_used+1] = clip16(comp[n_used] + pair_sz[i]);
            n_used++;
          end
        end
        for (int i = 0; i < n_pairs; i++) begin
          if (used[i] && run_res.size() < 64) begin
            e.result_kind   = KIND_PAIR;
            e.result_value  = 16'(i);
            e.row_not_found = 1'b0;
            e.last_result   = 1'b0;
            run_res.push_back(e);
          end
        end
        for (int i = 0; i < n_rows; i++) begin
          if (run_res.size() < 64) begin
            e.result_kind   = KIND_ROW;
            e.row_not_found = !fnd[i];
            e.last_result   = 1'b0;
            e.result_value  = fnd[i] ?
              16'(clip16(row_tgt[i] - off[hit[i]] + comp[rank[hit[i]]])) : 16'd0;
            run_res.push_back(e);
          end
        end
        if (run_res.size() > 0) run_res[run_res.size()-1].last_result = 1'b1;
        foreach (run_res[i]) remap_q.push_back(run_res[i]);
        n_pairs = 0;
        n_rows = 0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (remap_q.size() == 0) begin
        note_mismatch("result with none expected", out_data.result_value, 0);
      end else begin
        want_res = remap_q.pop_front();
        if (out_data.result_kind !== want_res.result_kind)
          note_mismatch("result_kind", out_data.result_kind, want_res.result_kind);
        if (out_data.result_value !== want_res.result_value)
          note_mismatch("result_value", out_data.result_value, want_res.result_value);
        if (out_data.row_not_found !== want_res.row_not_found)
          note_mismatch("row_not_found", out_data.row_not_found, want_res.row_not_found);
        if (out_data.last_result !== want_res.last_result)
          note_mismatch("last_result", out_data.last_result, want_res.last_result);
      end
    end
  end

  task automatic send_req(input in_req_t r);
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    predict_remap(r);
  endtask

  task automatic settle_results;
    start <= 1'b0;
    do @(posedge clk); while (busy || remap_q.size() != 0);
  endtask

  task automatic test_empty_run;
    send_req(mk(REQ_RUN, 7, 7, 16'hFFFF));
  endtask

  task automatic test_basic_remap;
    send_req(mk(REQ_LOAD_PAIR, 0, 0, 16'h0000));
    send_req(mk(REQ_LOAD_PAIR, 7, 7, 16'hFFFF));
    send_req(mk(REQ_LOAD_PAIR, 1, 2, 16'h0000));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd0));
    send_req(mk(REQ_LOAD_ROW, 7, 7, 16'd1297));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'hFFFF));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd1));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd1314));
    send_req(mk(REQ_RUN, 0, 0, 16'd0));
    settle_results;
  endtask

  task automatic test_unused_pairs;
    send_req(mk(REQ_LOAD_PAIR, 2, 0, 16'd0));
    send_req(mk(REQ_LOAD_PAIR, 0, 3, 16'd0));
    send_req(mk(REQ_LOAD_PAIR, 3, 3, 16'd0));
    send_req(mk(REQ_LOAD_PAIR, 7, 0, 16'd0));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd20));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd3));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd151));
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd152));
    send_req(mk(REQ_RUN, 0, 0, 16'd0));
  endtask

  task automatic test_rows_without_pairs;
    send_req(mk(REQ_LOAD_ROW, 0, 0, 16'd0));
    send_req(mk(REQ_RUN, 0, 0, 16'd0));
  endtask

  task automatic test_unknown_request;
    send_req(mk(REQ_UNKNOWN, 7, 7, 16'hFFFF));
    send_req(mk(REQ_UNKNOWN, 0, 0, 16'h0000));
  endtask

  // Overfills both lists and places one row in every pair, so that the run
  // gives the largest number of results.
  task automatic test_full_lists;
    int sz;
    int base;
    int sizes [MAX_PAIRS];
    int a;
    int b;
    base = 0;
    for (int i = 0; i < MAX_PAIRS + 2; i++) begin
      a = $urandom_range(0, 7);
      b = $urandom_range(0, 7);
      if (i < MAX_PAIRS) sizes[i] = orbital_count(a) * orbital_count(b);
      send_req(mk(REQ_LOAD_PAIR, a, b, 16'($urandom)));
    end
    for (int i = 0; i < MAX_ROWS + 2; i++) begin
      if (i % MAX_PAIRS == 0) base = 0;
      sz = sizes[i % MAX_PAIRS];
      send_req(mk(REQ_LOAD_ROW, $urandom, $urandom, 16'(base + $urandom_range(0, sz - 1))));
      base += sz;
    end
    send_req(mk(REQ_RUN, $urandom, $urandom, 16'($urandom)));
  endtask

  task automatic test_random_batches;
    int np;
    int nr;
    int total;
    int pi;
    int ri;
    int pick;
    int sent;
    int am_a [16];
    int am_b [16];
    logic [15:0] rws [16];
    sent = 0;
    while (sent < 16) begin
      gaps_on = !(sent >= 4 && sent < 10);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        nr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        total = 0;
        for (int i = 0; i < np; i++) begin
          am_a[i] = $urandom_range(0, 7);
          am_b[i] = $urandom_range(0, 7);
          total += orbital_count(am_a[i]) * orbital_count(am_b[i]);
        end
        for (int i = 0; i < nr; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) rws[i] = 16'($urandom_range(0, total - 1));
          else if (pick < 80) rws[i] = 16'(total);
          else if (pick < 85) rws[i] = 16'(total - 1);
          else rws[i] = 16'($urandom);
        end
        pi = 0;
        ri = 0;
        while (pi < np || ri < nr) begin
          if (ri >= nr || (pi < np && $urandom_range(0, 1) == 1)) begin
            send_req(mk(REQ_LOAD_PAIR, am_a[pi], am_b[pi], 16'($urandom)));
            pi++;
          end else begin
            send_req(mk(REQ_LOAD_ROW, $urandom, $urandom, rws[ri]));
            ri++;
          end
          if ($urandom_range(0, 19) == 0)
            send_req(mk(REQ_UNKNOWN, $urandom, $urandom, 16'($urandom)));
        end
        send_req(mk(REQ_RUN, $urandom, $urandom, 16'($urandom)));
        sent += np + nr + 1;
      end else if (pick < 90) begin
        nr = $urandom_range(1, 3);
        for (int i = 0; i < nr; i++)
          send_req(mk(REQ_LOAD_ROW, $urandom, $urandom, 16'($urandom)));
        send_req(mk(REQ_UNKNOWN, $urandom, $urandom, 16'($urandom)));
        send_req(mk(REQ_RUN, $urandom, $urandom, 16'($urandom)));
        sent += nr + 1;
      end else begin
        np = $urandom_range(0, 2);
        for (int i = 0; i < np; i++)
          send_req(mk(REQ_LOAD_PAIR, $urandom, $urandom, 16'($urandom)));
        send_req(mk(REQ_RUN, $urandom, $urandom, 16'($urandom)));
        sent += np + 1;
      end
      if ($urandom_range(0, 9) == 0) settle_results;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_run;
    test_basic_remap;
    test_unused_pairs;
    test_rows_without_pairs;
    test_unknown_request;
    gaps_on = 1'b0;
    test_full_lists;
    gaps_on = 1'b1;
    test_random_batches;
    settle_results;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (remap_q.size() != 0) note_mismatch("results never emitted", remap_q.size(), 0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
